@@ rtl/evhs_pkg.sv @@
package evhs_pkg;

  localparam logic [15:0] TPID_RESET = 16'h8100;
  localparam logic [11:0] VID_MASK   = 12'h0FFF;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // Header byte positions
  localparam logic [4:0] POS_SMAC_START = 5'd6;
  localparam logic [4:0] POS_TYPE_START = 5'd12;
  localparam logic [4:0] POS_TYPE0_END  = 5'd13;
  localparam logic [4:0] POS_TCI0_END   = 5'd15;
  localparam logic [4:0] POS_TYPE1_END  = 5'd17;
  localparam logic [4:0] POS_TCI1_END   = 5'd19;
  localparam logic [4:0] POS_TYPE2_END  = 5'd21;

  localparam logic [1:0] MAX_TAGS = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_TRUNC = 1'b1;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [47:0] dest_mac;
    logic [47:0] source_mac_addr;
    logic [11:0] outer_vid;
    logic [11:0] inner_vid;
    logic [15:0] payload_type;
    logic [1:0]  tags_seen;
    logic        parse_status;
  } out_item_t;

endpackage

@@ rtl/evhs_if.sv @@
interface evhs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink (input valid, frame_byte, frame_end, output ready);
endinterface

interface evhs_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  payload_byte;
  logic        payload_last;
  logic [47:0] dest_mac;
  logic [47:0] source_mac_addr;
  logic [11:0] outer_vid;
  logic [11:0] inner_vid;
  logic [15:0] payload_type;
  logic [1:0]  tags_seen;
  logic        parse_status;

  modport source (output valid, item_kind, payload_byte, payload_last, dest_mac,
                  source_mac_addr, outer_vid, inner_vid, payload_type, tags_seen,
                  parse_status, input ready);
  modport sink (input valid, item_kind, payload_byte, payload_last, dest_mac,
                source_mac_addr, outer_vid, inner_vid, payload_type, tags_seen,
                parse_status, output ready);
endinterface

interface evhs_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ rtl/evhs_front.sv @@
module evhs_front (
  input  logic                clk,
  input  logic                rst,
  evhs_in_if.sink             frame_in,
  evhs_cfg_if.sink            cfg,
  output evhs_pkg::out_item_t push_item,
  output logic                push_valid,
  input  logic                push_ready
);
  import evhs_pkg::*;

  logic [15:0] tag_protocol_id;
  logic [4:0]  byte_position;
  logic        in_payload;
  logic [47:0] dest_mac_reg;
  logic [47:0] source_mac_reg;
  logic [15:0] type_shift;
  logic [11:0] outer_vid_reg;
  logic [11:0] inner_vid_reg;
  logic [1:0]  tag_count;

  logic [47:0] dest_mac_next;
  logic [47:0] source_mac_next;
  logic [15:0] type_next;
  logic [11:0] outer_vid_next;
  logic [11:0] inner_vid_next;
  logic [1:0]  tag_count_next;
  logic        type_check;
  logic        done;
  logic        accept;

  assign cfg.ready      = 1'b1;
  assign frame_in.ready = push_ready;
  assign accept         = frame_in.valid & push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_protocol_id <= TPID_RESET;
    end else if (cfg.valid) begin
      tag_protocol_id <= cfg.data;
    end
  end

  always_comb begin
    dest_mac_next   = dest_mac_reg;
    source_mac_next = source_mac_reg;
    type_next       = type_shift;
    outer_vid_next  = outer_vid_reg;
    inner_vid_next  = inner_vid_reg;
    tag_count_next  = tag_count;
    type_check      = 1'b0;
    if (byte_position < POS_SMAC_START) begin
      dest_mac_next = {dest_mac_reg[39:0], frame_in.frame_byte};
    end else if (byte_position < POS_TYPE_START) begin
      source_mac_next = {source_mac_reg[39:0], frame_in.frame_byte};
    end else begin
      type_next = {type_shift[7:0], frame_in.frame_byte};
      if (byte_position == POS_TCI0_END) begin
        outer_vid_next = type_next[11:0] & VID_MASK;
        tag_count_next = 2'd1;
      end else if (byte_position == POS_TCI1_END) begin
        inner_vid_next = type_next[11:0] & VID_MASK;
        tag_count_next = MAX_TAGS;
      end else if (byte_position == POS_TYPE0_END || byte_position == POS_TYPE1_END ||
                   byte_position == POS_TYPE2_END) begin
        type_check = 1'b1;
      end
    end
  end

  // A tag follows only while the ethertype matches and a tag slot is left
  assign done = !in_payload && type_check &&
                !(type_next == tag_protocol_id && tag_count < MAX_TAGS);

  always_comb begin
    push_valid = accept & (in_payload | done | frame_in.frame_end);
    push_item  = '0;
    if (in_payload) begin
      push_item.item_kind    = KIND_PAYLOAD;
      push_item.payload_byte = frame_in.frame_byte;
      push_item.payload_last = frame_in.frame_end;
    end else begin
      push_item.item_kind       = KIND_SUMMARY;
      push_item.payload_last    = done ? frame_in.frame_end : 1'b1;
      push_item.dest_mac        = dest_mac_next;
      push_item.source_mac_addr = source_mac_next;
      push_item.outer_vid       = outer_vid_next;
      push_item.inner_vid       = inner_vid_next;
      push_item.payload_type    = done ? type_next : 16'd0;
      push_item.tags_seen       = tag_count_next;
      push_item.parse_status    = done ? STATUS_OK : STATUS_TRUNC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      in_payload     <= 1'b0;
      dest_mac_reg   <= '0;
      source_mac_reg <= '0;
      type_shift     <= '0;
      outer_vid_reg  <= '0;
      inner_vid_reg  <= '0;
      tag_count      <= '0;
    end else if (accept) begin
      if (frame_in.frame_end) begin
        // Clear everything so the next transaction starts a new frame
        byte_position  <= '0;
        in_payload     <= 1'b0;
        dest_mac_reg   <= '0;
        source_mac_reg <= '0;
        type_shift     <= '0;
        outer_vid_reg  <= '0;
        inner_vid_reg  <= '0;
        tag_count      <= '0;
      end else if (!in_payload) begin
        if (done) begin
          in_payload <= 1'b1;
        end else begin
          byte_position <= byte_position + 5'd1;
        end
        dest_mac_reg   <= dest_mac_next;
        source_mac_reg <= source_mac_next;
        type_shift     <= type_next;
        outer_vid_reg  <= outer_vid_next;
        inner_vid_reg  <= inner_vid_next;
        tag_count      <= tag_count_next;
      end
    end
  end

endmodule

@@ rtl/evhs_queue.sv @@
module evhs_queue #(
  parameter int unsigned DEPTH = evhs_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  evhs_pkg::out_item_t push_item,
  input  logic                push_valid,
  output logic                push_ready,
  output evhs_pkg::out_item_t pop_item,
  output logic                pop_valid,
  input  logic                pop_ready
);
  import evhs_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  out_item_t        mem [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + IDX_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + IDX_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/evhs_back.sv @@
module evhs_back (
  input  logic                clk,
  input  logic                rst,
  input  evhs_pkg::out_item_t pop_item,
  input  logic                pop_valid,
  output logic                pop_ready,
  evhs_out_if.source          item_out
);
  import evhs_pkg::*;

  out_item_t out_reg;
  logic      out_valid;

  // Load a new transaction whenever the output register is empty or draining
  assign pop_ready = !out_valid || item_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_ready) begin
      out_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      out_reg <= pop_item;
    end
  end

  assign item_out.valid           = out_valid;
  assign item_out.item_kind       = out_reg.item_kind;
  assign item_out.payload_byte    = out_reg.payload_byte;
  assign item_out.payload_last    = out_reg.payload_last;
  assign item_out.dest_mac        = out_reg.dest_mac;
  assign item_out.source_mac_addr = out_reg.source_mac_addr;
  assign item_out.outer_vid       = out_reg.outer_vid;
  assign item_out.inner_vid       = out_reg.inner_vid;
  assign item_out.payload_type    = out_reg.payload_type;
  assign item_out.tags_seen       = out_reg.tags_seen;
  assign item_out.parse_status    = out_reg.parse_status;

endmodule

@@ rtl/ethernet_vlan_header_stripper_top.sv @@
// Channel    Dir  Payload
// frame_in   in   frame_byte[7:0], frame_end
// item_out   out  item_kind, payload_byte, payload_last, MACs, VLAN ids, type, status
// cfg        in   data[15:0] -> tag protocol id
//
// One frame byte is accepted per cycle while the queue is not full; the parser front end
// updates its header registers while in the header and pushes at most one transaction into the queue.
// A result reaches item_out through the queue and then the output register.
// Synchronous reset clears the header state, the queue and the output register and
// loads the tag protocol id with 0x8100. Back-pressure on item_out fills the queue,
// and frame_in.ready drops only when the queue is full.
module ethernet_vlan_header_stripper_top #(
  parameter int unsigned QUEUE_DEPTH = evhs_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  evhs_in_if.sink     frame_in,
  evhs_cfg_if.sink    cfg,
  evhs_out_if.source  item_out
);
  import evhs_pkg::*;

  out_item_t push_item;
  logic      push_valid;
  logic      push_ready;
  out_item_t pop_item;
  logic      pop_valid;
  logic      pop_ready;

  evhs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .frame_in   (frame_in),
    .cfg        (cfg),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  evhs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_item   (pop_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  evhs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_item  (pop_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .item_out  (item_out)
  );

endmodule
